// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int ITEM_W      = 32;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // one held entry
    typedef struct packed {
        logic signed [ITEM_W-1:0] item;
        logic signed [KEY_W-1:0]  key;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t fresh;
    } cell_cmd_t;

endpackage

// ===== hdl/spq_in_if.sv =====
interface spq_in_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [ITEM_W-1:0] item_value;
    logic signed [KEY_W-1:0]  item_rank_key;

    modport source (output valid, output func, output item_value, output item_rank_key,
                    input ready);
    modport sink   (input valid, input func, input item_value, input item_rank_key,
                    output ready);
endinterface

// ===== hdl/spq_out_if.sv =====
interface spq_out_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [ITEM_W-1:0] popped_item;
    logic [POS_W-1:0]         insert_position;
    logic signed [ITEM_W-1:0] front_item;
    logic signed [ITEM_W-1:0] back_item;
    logic [COUNT_W-1:0]       entry_count;

    modport source (output valid, output status, output popped_item, output insert_position,
                    output front_item, output back_item, output entry_count, input ready);
    modport sink   (input valid, input status, input popped_item, input insert_position,
                    input front_item, input back_item, input entry_count, output ready);
endinterface

// ===== hdl/spq_cell.sv =====
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_le,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               le,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // held key at or below the new key: this cell stays in front of it
    assign le    = occupied && ($signed(entry_reg.key) <= $signed(cmd.fresh.key));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !le)
        begin
            entry_next = left_le ? cmd.fresh : left_entry;
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/sorted_array_priority_queue.sv =====
// sorted priority queue built as a row of DEPTH cells, one entry per cell, kept in
// ascending key order with cell 0 at the front. an insert beat is broadcast to all
// cells at once: each cell compares its key with the new one, the cells holding a
// key at or below it stay put, the first cell past them takes the new entry and the
// rest shift one place back, so equal keys leave in arrival order. a pop shifts every
// cell one place forward. the cells update in the cycle a beat is accepted; its
// result then waits in the first stage until the output register is free, when
// the front and back cells are read in. a new beat is taken as soon as that result
// has moved into the output register, even while it waits there to be taken. an insert
// into a full queue reports overflow and a pop from an empty queue reports underflow
// with item zero; neither changes the contents. insert_position and entry_count wrap
// at their field widths when DEPTH is larger than they can show. entries past the
// count are never shown, so the cells need no clearing after reset.
module sorted_array_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);   // count, holds DEPTH itself
    localparam int IW = $clog2(DEPTH);       // cell index

    // queue state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result waiting for the output register
    logic                     pend_reg;
    status_t                  status_reg;
    logic signed [ITEM_W-1:0] popped_reg;
    logic [IW-1:0]            pos_reg;

    // output register
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [ITEM_W-1:0] out_popped_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic signed [ITEM_W-1:0] out_front_reg;
    logic signed [ITEM_W-1:0] out_back_reg;
    logic [COUNT_W-1:0]       out_count_reg;

    logic          accept;
    logic          full;
    logic          empty;
    logic          is_pop;
    logic          load_out;
    cell_cmd_t     cmd;
    logic [DEPTH-1:0] le;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] occupied;
    entry_t        cell_entry [DEPTH];
    logic [IW-1:0] pos;
    status_t       status;
    logic [CW-1:0] last;
    logic [IW-1:0] back_idx;
    logic [IW+POS_W-1:0] pos_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    assign req.ready = !pend_reg;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign is_pop    = (req.func == FUNC_POP);

    // a rejected operation leaves the cells alone
    assign cmd.ins         = accept && !is_pop && !full;
    assign cmd.pop         = accept && is_pop && !empty;
    assign cmd.fresh.item  = req.item_value;
    assign cmd.fresh.key   = req.item_rank_key;

    // the row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occupied[i] = (CW'(i) < count_reg);

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (occupied[i]),
            .left_le     ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
            .le          (le[i]),
            .entry       (cell_entry[i])
        );

        // landing cell: first one whose key is above the new key, or first empty
        assign hit[i] = !le[i] && ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]);
    end

    // encode the landing cell, one hot whenever the queue is not full
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit[i])
            begin
                pos = pos | IW'(i);
            end
        end
    end

    always_comb
    begin
        status = STATUS_OK;
        if (!is_pop && full)
        begin
            status = STATUS_OVERFLOW;
        end
        else if (is_pop && empty)
        begin
            status = STATUS_UNDERFLOW;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // first stage: status, popped item and landing rank of the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg <= 1'b1;
        end
        else if (load_out)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            popped_reg <= cmd.pop ? cell_entry[0].item : '0;
            pos_reg    <= cmd.ins ? pos : '0;
        end
    end

    // second stage: cells have settled, read front and back into the output register
    assign load_out  = pend_reg && (!out_valid_reg || rsp.ready);
    assign last      = count_reg - 1'b1;
    assign back_idx  = last[IW-1:0];
    assign pos_ext   = (IW + POS_W)'(pos_reg);
    assign count_ext = (CW + COUNT_W)'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_popped_reg <= popped_reg;
            out_pos_reg    <= pos_ext[POS_W-1:0];
            out_front_reg  <= empty ? '0 : cell_entry[0].item;
            out_back_reg   <= empty ? '0 : cell_entry[back_idx].item;
            out_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.popped_item     = out_popped_reg;
    assign rsp.insert_position = out_pos_reg;
    assign rsp.front_item      = out_front_reg;
    assign rsp.back_item       = out_back_reg;
    assign rsp.entry_count     = out_count_reg;

endmodule
